### src/avdh_pkg.sv
// Shared types and constants for the voice activity detector with hangover.
package avdh_pkg;

   localparam int SampleWidth = 16;
   localparam int ThrWidth    = 13;
   localparam int Thr2Width   = 2 * ThrWidth;
   localparam int EnergyWidth = 40;
   localparam int SquareWidth = 2 * SampleWidth;
   localparam int SeqWidth    = 16;
   localparam int LenWidth    = 9;
   localparam int CsrIdxWidth = 2;

   localparam logic [ThrWidth-1:0] ThrReset = 13'd1120;

   // Configuration register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_RATE_16K      = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_VAD_ENABLE    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CSR_VAD_THRESHOLD = 2'd2;

   typedef struct packed {
      logic                rate_16k;
      logic                vad_enable;
      logic [ThrWidth-1:0] vad_threshold;
   } cfg_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_SEND   = 1'b1
   } cmd_kind_type;

   // Classified input beat as it waits between front and back
   typedef struct packed {
      cmd_kind_type                   kind;
      logic signed [SampleWidth-1:0]  sample;
      logic                           last;
   } cmd_type;

   typedef struct packed {
      logic signed [SampleWidth-1:0] out_sample;
      logic                          sample_valid;
      logic                          frame_end;
      logic                          frame_keep;
      logic [SeqWidth-1:0]           frame_seq;
      logic                          flag_wide;
      logic                          flag_speech;
      logic                          flag_gate_on;
      logic [LenWidth-1:0]           frame_length;
   } rsp_type;

endpackage

### src/avdh_fifo.sv
// Small register-based queue with first-word-fall-through read.
module avdh_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] PtrLast  = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] CntDepth = CntWidth'(DEPTH);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full    = (count_ff == CntDepth);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CntWidth'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

### src/avdh_front.sv
// Front end: accepts input beats, classifies them and queues them for the back end.
module avdh_front #(
   parameter int DEPTH = 2
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 push,
   output logic                                 full,
   input  logic                                 req_opcode,
   input  logic signed [avdh_pkg::SampleWidth-1:0] req_sample,
   input  logic                                 req_frame_last,
   input  logic                                 req_send_ok,
   output avdh_pkg::cmd_type                    cmd_head,
   output logic                                 cmd_empty,
   input  logic                                 cmd_pop
);

   import avdh_pkg::*;

   localparam int CmdWidth = $bits(cmd_type);

   cmd_type             cmd_new;
   logic                useful;
   logic [CmdWidth-1:0] head_bits;

   // Classify: a failed send report changes nothing, so it is absorbed here
   always_comb begin
      cmd_new.kind   = req_opcode ? CMD_SEND : CMD_SAMPLE;
      cmd_new.sample = req_sample;
      cmd_new.last   = req_frame_last;
      useful         = !req_opcode || req_send_ok;
   end

   avdh_fifo #(
      .WIDTH (CmdWidth),
      .DEPTH (DEPTH)
   ) u_cmd_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push && useful),
      .wdata (cmd_new),
      .full  (full),
      .pop   (cmd_pop),
      .rdata (head_bits),
      .empty (cmd_empty)
   );

   assign cmd_head = cmd_type'(head_bits);

endmodule

### src/avdh_back.sv
// Back end: decimation, energy accumulation, frame verdict and hangover sequencer.
module avdh_back #(
   parameter int FRAME_SAMPLES   = 320,
   parameter int HANGOVER_FRAMES = 15
) (
   input  logic              clock,
   input  logic              reset,
   input  avdh_pkg::cfg_type cfg,
   input  avdh_pkg::cmd_type cmd_head,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   output avdh_pkg::rsp_type rsp_data,
   output logic              rsp_push,
   input  logic              rsp_full
);

   import avdh_pkg::*;

   localparam int CntWidth  = $clog2(FRAME_SAMPLES + 1);
   localparam int HoldWidth = $clog2(HANGOVER_FRAMES + 1);
   localparam int LimWidth  = Thr2Width + CntWidth;
   localparam int CmpWidth  = (LimWidth > EnergyWidth) ? LimWidth : EnergyWidth;
   localparam logic [CntWidth-1:0]  FrameMax = CntWidth'(FRAME_SAMPLES);
   localparam logic [HoldWidth-1:0] HoldLoad = HoldWidth'(HANGOVER_FRAMES);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SQUARE,
      S_ACCUM,
      S_THR,
      S_MUL,
      S_DECIDE,
      S_EMIT
   } state_type;

   state_type                     state_ff, state_in;
   logic signed [SampleWidth-1:0] outv_ff, outv_in;
   logic                          valid_ff, valid_in;
   logic                          last_ff, last_in;
   logic [SquareWidth-1:0]        sq_ff, sq_in;
   logic [Thr2Width-1:0]          thr2_ff, thr2_in;
   logic [LimWidth-1:0]           lim_ff, lim_in;
   rsp_type                       rsp_ff, rsp_in;
   logic signed [SampleWidth-1:0] pair_first_ff, pair_first_in;
   logic                          pair_phase_ff, pair_phase_in;
   logic [EnergyWidth-1:0]        energy_ff, energy_in;
   logic [CntWidth-1:0]           count_ff, count_in;
   logic [HoldWidth-1:0]          hold_ff, hold_in;
   logic [SeqWidth-1:0]           seq_ff, seq_in;

   logic signed [SampleWidth:0]   pair_sum, pair_adj;
   logic signed [SquareWidth-1:0] sq_full;
   logic [EnergyWidth:0]          energy_add;
   logic [CntWidth+LenWidth-1:0]  len_ext;
   logic                          loud;

   // Pair average truncated toward zero, square, saturating add, frame compare
   always_comb begin
      pair_sum   = {pair_first_ff[SampleWidth-1], pair_first_ff}
                 + {cmd_head.sample[SampleWidth-1], cmd_head.sample};
      pair_adj   = pair_sum + {{SampleWidth{1'b0}}, pair_sum[SampleWidth]};
      sq_full    = SquareWidth'(outv_ff) * SquareWidth'(outv_ff);
      energy_add = {1'b0, energy_ff} + (EnergyWidth + 1)'(sq_ff);
      len_ext    = (CntWidth + LenWidth)'(count_ff);
      loud       = (count_ff != '0) ? (CmpWidth'(energy_ff) >= CmpWidth'(lim_ff))
                                    : (thr2_ff == '0);
   end

   // Sequencer next state
   always_comb begin
      logic voiced;
      voiced        = 1'b1;
      state_in      = state_ff;
      outv_in       = outv_ff;
      valid_in      = valid_ff;
      last_in       = last_ff;
      sq_in         = sq_ff;
      thr2_in       = thr2_ff;
      lim_in        = lim_ff;
      rsp_in        = rsp_ff;
      pair_first_in = pair_first_ff;
      pair_phase_in = pair_phase_ff;
      energy_in     = energy_ff;
      count_in      = count_ff;
      hold_in       = hold_ff;
      seq_in        = seq_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_head.kind == CMD_SEND) begin
                  seq_in = seq_ff + SeqWidth'(1);
               end else begin
                  outv_in  = '0;
                  valid_in = 1'b0;
                  last_in  = cmd_head.last;
                  if (count_ff < FrameMax) begin
                     if (cfg.rate_16k) begin
                        outv_in  = cmd_head.sample;
                        valid_in = 1'b1;
                     end else if (!pair_phase_ff) begin
                        pair_first_in = cmd_head.sample;
                        pair_phase_in = 1'b1;
                     end else begin
                        outv_in       = pair_adj[SampleWidth:1];
                        pair_phase_in = 1'b0;
                        valid_in      = 1'b1;
                     end
                  end
                  state_in = S_SQUARE;
               end
            end
         end
         S_SQUARE: begin
            sq_in    = unsigned'(sq_full);
            state_in = S_ACCUM;
         end
         S_ACCUM: begin
            if (valid_ff) begin
               energy_in = energy_add[EnergyWidth] ? '1 : energy_add[EnergyWidth-1:0];
               count_in  = count_ff + CntWidth'(1);
            end
            rsp_in              = '0;
            rsp_in.out_sample   = outv_ff;
            rsp_in.sample_valid = valid_ff;
            if (last_ff) begin
               state_in = S_THR;
            end else if (valid_ff) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_THR: begin
            thr2_in  = Thr2Width'(cfg.vad_threshold) * Thr2Width'(cfg.vad_threshold);
            state_in = S_MUL;
         end
         S_MUL: begin
            // floor(sum / count) >= thr^2 is sum >= thr^2 * count
            lim_in   = LimWidth'(thr2_ff) * LimWidth'(count_ff);
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (cfg.vad_enable) begin
               if (loud) begin
                  hold_in = HoldLoad;
               end else if (hold_ff != '0) begin
                  hold_in = hold_ff - HoldWidth'(1);
               end
               voiced = (hold_in != '0);
               if (!voiced) begin
                  seq_in = seq_ff + SeqWidth'(1);
               end
            end
            rsp_in.frame_end    = 1'b1;
            rsp_in.frame_keep   = voiced;
            rsp_in.frame_seq    = seq_ff;
            rsp_in.flag_wide    = cfg.rate_16k;
            rsp_in.flag_speech  = voiced;
            rsp_in.flag_gate_on = cfg.vad_enable;
            rsp_in.frame_length = len_ext[LenWidth-1:0];
            energy_in     = '0;
            count_in      = '0;
            pair_phase_in = 1'b0;
            pair_first_in = '0;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      outv_ff  <= outv_in;
      valid_ff <= valid_in;
      last_ff  <= last_in;
      sq_ff    <= sq_in;
      thr2_ff  <= thr2_in;
      lim_ff   <= lim_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         pair_first_ff <= '0;
         pair_phase_ff <= 1'b0;
         energy_ff     <= '0;
         count_ff      <= '0;
         hold_ff       <= '0;
         seq_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         pair_first_ff <= pair_first_in;
         pair_phase_ff <= pair_phase_in;
         energy_ff     <= energy_in;
         count_ff      <= count_in;
         hold_ff       <= hold_in;
         seq_ff        <= seq_in;
      end
   end

   assign rsp_data = rsp_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FrameMax)
      else $error("kept sample count beyond frame size");

   a_no_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (rsp_ff.sample_valid || rsp_ff.frame_end))
      else $error("result beat with neither sample nor frame close");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DECIDE) |=> (energy_ff == '0 && count_ff == '0 && !pair_phase_ff))
      else $error("frame state not cleared at frame close");

   a_gate_off_keep: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_ff.frame_end && !rsp_ff.flag_gate_on) |-> rsp_ff.frame_keep)
      else $error("frame dropped with voice gate off");
`endif

endmodule

### src/audio_decimate_vad_hangover_top.sv
// Top level of the decimating energy voice activity detector with hangover.
//
//   channel  | handshake            | payload
//   ---------+----------------------+---------------------------------------------
//   req      | push / full          | req_opcode, req_sample, req_frame_last, req_send_ok
//   rsp      | empty / pop          | rsp_out_sample ... rsp_frame_length
//   csr      | csr_valid / csr_ready| csr_index, csr_wdata
//
// A sample beat that gives a result passes the back-end sequencer states dequeue, square,
// accumulate and emit; one that gives none skips emit; one that closes a frame adds the
// threshold square, threshold-times-count product and compare before emit. A sent report
// is handled at dequeue, a failed one is absorbed by the front end. Emit waits while the
// result queue is full. Reset clears the sequencer, pointers, counters and configuration.
// Two-beat queues on each side let both sides stall independently; csr_ready stays high.
module audio_decimate_vad_hangover_top #(
   parameter int FRAME_SAMPLES   = 320,
   parameter int HANGOVER_FRAMES = 15
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    push,
   output logic                                    full,
   input  logic                                    req_opcode,
   input  logic signed [avdh_pkg::SampleWidth-1:0] req_sample,
   input  logic                                    req_frame_last,
   input  logic                                    req_send_ok,
   output logic                                    empty,
   input  logic                                    pop,
   output logic signed [avdh_pkg::SampleWidth-1:0] rsp_out_sample,
   output logic                                    rsp_sample_valid,
   output logic                                    rsp_frame_end,
   output logic                                    rsp_frame_keep,
   output logic [avdh_pkg::SeqWidth-1:0]           rsp_frame_seq,
   output logic                                    rsp_flag_wide,
   output logic                                    rsp_flag_speech,
   output logic                                    rsp_flag_gate_on,
   output logic [avdh_pkg::LenWidth-1:0]           rsp_frame_length,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [avdh_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [avdh_pkg::ThrWidth-1:0]           csr_wdata
);

   import avdh_pkg::*;

   localparam int RspWidth = $bits(rsp_type);

   cfg_type             cfg_ff, cfg_in;
   cmd_type             cmd_head;
   logic                cmd_empty;
   logic                cmd_pop;
   rsp_type             rsp_data;
   logic                rsp_push;
   logic                rsp_full;
   logic [RspWidth-1:0] rsp_bits;
   rsp_type             rsp_head;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RATE_16K:      cfg_in.rate_16k      = csr_wdata[0];
            CSR_VAD_ENABLE:    cfg_in.vad_enable    = csr_wdata[0];
            CSR_VAD_THRESHOLD: cfg_in.vad_threshold = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_16k      <= 1'b0;
         cfg_ff.vad_enable    <= 1'b0;
         cfg_ff.vad_threshold <= ThrReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   avdh_front #(
      .DEPTH (2)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_opcode     (req_opcode),
      .req_sample     (req_sample),
      .req_frame_last (req_frame_last),
      .req_send_ok    (req_send_ok),
      .cmd_head       (cmd_head),
      .cmd_empty      (cmd_empty),
      .cmd_pop        (cmd_pop)
   );

   avdh_back #(
      .FRAME_SAMPLES   (FRAME_SAMPLES),
      .HANGOVER_FRAMES (HANGOVER_FRAMES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_head  (cmd_head),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_data),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   // Result queue toward the consumer
   avdh_fifo #(
      .WIDTH (RspWidth),
      .DEPTH (2)
   ) u_rsp_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .wdata (rsp_data),
      .full  (rsp_full),
      .pop   (pop),
      .rdata (rsp_bits),
      .empty (empty)
   );

   assign rsp_head         = rsp_type'(rsp_bits);
   assign rsp_out_sample   = rsp_head.out_sample;
   assign rsp_sample_valid = rsp_head.sample_valid;
   assign rsp_frame_end    = rsp_head.frame_end;
   assign rsp_frame_keep   = rsp_head.frame_keep;
   assign rsp_frame_seq    = rsp_head.frame_seq;
   assign rsp_flag_wide    = rsp_head.flag_wide;
   assign rsp_flag_speech  = rsp_head.flag_speech;
   assign rsp_flag_gate_on = rsp_head.flag_gate_on;
   assign rsp_frame_length = rsp_head.frame_length;

endmodule
